// File: rtl/core/mtg_pkg.sv
// shared types, codes and reset values of the motor thermal guard
`default_nettype none

package mtg_pkg;

  // default widths for the top level parameters
  localparam int TEMP_BITS_DEF = 12;
  localparam int WAIT_BITS_DEF = 24;

  // configuration register widths and port geometry
  localparam int LIMIT_W   = 11;
  localparam int TIMEOUT_W = 24;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 4;
  localparam int REG_IDX_W = 2;

  // register indexes on the configuration port
  localparam logic [REG_IDX_W-1:0] REG_LIMIT   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_HYST    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_TIMEOUT = 2'd2;

  // register reset values
  localparam logic [LIMIT_W-1:0]   LIMIT_RST   = 11'd600;
  localparam logic [LIMIT_W-1:0]   HYST_RST    = 11'd200;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 24'd1000000;

  // input commands
  localparam int CMD_W = 2;
  localparam logic [CMD_W-1:0] CMD_TEMP   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BUTTON = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

  // alarm / status codes
  localparam int STAT_W = 2;
  localparam logic [STAT_W-1:0] ST_NORMAL       = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERHEAT     = 2'd1;
  localparam logic [STAT_W-1:0] ST_SENSOR_FAULT = 2'd2;
  localparam logic [STAT_W-1:0] ST_SEAL_FAULT   = 2'd3;

  // control flags of the guard
  typedef struct packed {
    logic              relay_state;
    logic              stop_pending;
    logic [STAT_W-1:0] alarm_code;
    logic              alarm_seen;
    logic              resume_run;
  } flags_t;

  localparam flags_t FLAGS_RST = '{
    relay_state:  1'b0,
    stop_pending: 1'b0,
    alarm_code:   ST_NORMAL,
    alarm_seen:   1'b0,
    resume_run:   1'b0
  };

  // one result beat
  typedef struct packed {
    logic              motor_on;
    logic              buzzer_on;
    logic              alarm_led;
    logic [STAT_W-1:0] status;
    logic              stopping;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/mtg_core.sv
// next-state and result logic of the guard for one event
`default_nettype none

module mtg_core #(
  parameter int TEMP_BITS = mtg_pkg::TEMP_BITS_DEF,
  parameter int WAIT_BITS = mtg_pkg::WAIT_BITS_DEF
) (
  input  wire mtg_pkg::flags_t                 flags_cur,
  input  wire logic [WAIT_BITS-1:0]            wait_cur,
  input  wire logic [mtg_pkg::CMD_W-1:0]       cmd,
  input  wire logic signed [TEMP_BITS-1:0]     temperature,
  input  wire logic                            sensor_fail,
  input  wire logic                            sealed,
  input  wire logic [mtg_pkg::LIMIT_W-1:0]     limit,
  input  wire logic [mtg_pkg::LIMIT_W-1:0]     hyst,
  input  wire logic [WAIT_BITS-1:0]            timeout,
  output mtg_pkg::flags_t                      flags_nxt,
  output logic [WAIT_BITS-1:0]                 wait_nxt,
  output mtg_pkg::result_t                     res
);

  // compare width covers the reading and limit minus hysteresis
  localparam int CW = ((TEMP_BITS > mtg_pkg::LIMIT_W) ? TEMP_BITS : mtg_pkg::LIMIT_W) + 2;

  logic signed [CW-1:0] temp_s;
  logic signed [CW-1:0] lim_s;
  logic signed [CW-1:0] clr_s;
  logic                 fault_now;

  // signed thresholds
  always_comb begin
    temp_s = CW'(temperature);
    lim_s  = $signed(CW'(limit));
    clr_s  = lim_s - $signed(CW'(hyst));
  end

  // event handling then alarm follow-up
  always_comb begin
    flags_nxt = flags_cur;
    wait_nxt  = wait_cur;

    case (cmd)
      mtg_pkg::CMD_TEMP: begin
        if (!flags_cur.alarm_code[1]) begin
          if (sensor_fail || temp_s[CW-1] || (temp_s == '0)) begin
            flags_nxt.alarm_code = mtg_pkg::ST_SENSOR_FAULT;
          end else begin
            if (temp_s >= lim_s) begin
              flags_nxt.alarm_code = mtg_pkg::ST_OVERHEAT;
            end
            if ((temp_s < clr_s) && (flags_nxt.alarm_code == mtg_pkg::ST_OVERHEAT)) begin
              flags_nxt.alarm_code = mtg_pkg::ST_NORMAL;
            end
          end
        end
      end
      mtg_pkg::CMD_BUTTON: begin
        if (flags_cur.alarm_code == mtg_pkg::ST_OVERHEAT) begin
          flags_nxt.resume_run = 1'b0;
        end else if ((flags_cur.alarm_code == mtg_pkg::ST_NORMAL) &&
                     !flags_cur.stop_pending) begin
          if (!flags_cur.relay_state) begin
            flags_nxt.relay_state = 1'b1;
          end else if (!sealed) begin
            flags_nxt.relay_state  = 1'b0;
            flags_nxt.stop_pending = 1'b0;
            wait_nxt               = '0;
          end else begin
            flags_nxt.stop_pending = 1'b1;
            wait_nxt               = timeout;
          end
        end
      end
      mtg_pkg::CMD_TICK: begin
        if (flags_cur.stop_pending) begin
          if (!sealed) begin
            flags_nxt.relay_state  = 1'b0;
            flags_nxt.stop_pending = 1'b0;
            wait_nxt               = '0;
          end else if (wait_cur <= WAIT_BITS'(1)) begin
            flags_nxt.relay_state  = 1'b0;
            flags_nxt.stop_pending = 1'b0;
            wait_nxt               = '0;
            flags_nxt.alarm_code   = mtg_pkg::ST_SEAL_FAULT;
          end else begin
            wait_nxt = wait_cur - WAIT_BITS'(1);
          end
        end
      end
      default: begin
      end
    endcase

    // alarm entry stops the motor, alarm exit may resume it
    fault_now = flags_nxt.alarm_code[1];
    if (flags_nxt.alarm_code != mtg_pkg::ST_NORMAL) begin
      if (!flags_nxt.alarm_seen) begin
        flags_nxt.alarm_seen = 1'b1;
        flags_nxt.resume_run = flags_nxt.relay_state;
      end
      if (fault_now) begin
        flags_nxt.resume_run = 1'b0;
      end
      if (flags_nxt.relay_state && !flags_nxt.stop_pending) begin
        if (!sealed) begin
          flags_nxt.relay_state  = 1'b0;
          flags_nxt.stop_pending = 1'b0;
          wait_nxt               = '0;
        end else begin
          flags_nxt.stop_pending = 1'b1;
          wait_nxt               = timeout;
        end
      end
    end else if (flags_nxt.alarm_seen) begin
      flags_nxt.alarm_seen = 1'b0;
      if (flags_nxt.resume_run) begin
        flags_nxt.relay_state  = 1'b1;
        flags_nxt.stop_pending = 1'b0;
        wait_nxt               = '0;
      end
      flags_nxt.resume_run = 1'b0;
    end
  end

  // result fields from the updated state
  always_comb begin
    res.motor_on  = flags_nxt.relay_state;
    res.buzzer_on = flags_nxt.alarm_code[1];
    res.alarm_led = (flags_nxt.alarm_code != mtg_pkg::ST_NORMAL);
    res.status    = flags_nxt.alarm_code;
    res.stopping  = flags_nxt.stop_pending;
  end

endmodule

`default_nettype wire

// File: rtl/core/motor_thermal_guard_controller_unit.sv
// top level of the motor thermal guard controller
`default_nettype none

// Motor relay controller with thermal protection. Each input beat carries one
// event (temperature reading, button press or control tick) and yields exactly
// one result beat with relay, buzzer, alarm LED, status and stopping outputs.
// The block takes one beat per clock: a beat is captured in an input register,
// the guard state and the result are then computed from it and written to the
// output register once that is free or draining, and throughput is one beat per
// cycle, limited only by downstream back-pressure on out_ready.
// Sensor and seal faults latch until reset. Limit, hysteresis and seal timeout
// are written through the APB port at byte addresses 0, 4 and 8; the user must
// write them only while idle, as the block itself does not enforce this.

module motor_thermal_guard_controller_unit #(
  parameter int TEMP_BITS = mtg_pkg::TEMP_BITS_DEF,
  parameter int WAIT_BITS = mtg_pkg::WAIT_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input channel
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [mtg_pkg::CMD_W-1:0]        in_cmd,
  input  wire logic signed [TEMP_BITS-1:0]      in_temperature,
  input  wire logic                             in_sensor_fail,
  input  wire logic                             in_sealed,
  // result channel
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_motor_on,
  output logic                                  out_buzzer_on,
  output logic                                  out_alarm_led,
  output logic [mtg_pkg::STAT_W-1:0]            out_status,
  output logic                                  out_stopping,
  // configuration port
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [mtg_pkg::ADDR_W-1:0]       paddr,
  input  wire logic [mtg_pkg::DATA_W-1:0]       pwdata,
  output logic [mtg_pkg::DATA_W-1:0]            prdata,
  output logic                                  pready
);

  logic [mtg_pkg::LIMIT_W-1:0]    limit_r;
  logic [mtg_pkg::LIMIT_W-1:0]    hyst_r;
  logic [mtg_pkg::TIMEOUT_W-1:0]  timeout_r;
  logic [WAIT_BITS-1:0]           timeout_w;
  logic [mtg_pkg::REG_IDX_W-1:0]  reg_idx;
  logic                           cfg_wr;

  logic                           stg_valid_r;
  logic [mtg_pkg::CMD_W-1:0]      stg_cmd_r;
  logic signed [TEMP_BITS-1:0]    stg_temp_r;
  logic                           stg_fail_r;
  logic                           stg_sealed_r;
  logic                           advance;

  mtg_pkg::flags_t                flags_r;
  mtg_pkg::flags_t                flags_nxt;
  logic [WAIT_BITS-1:0]           wait_count_r;
  logic [WAIT_BITS-1:0]           wait_count_nxt;
  mtg_pkg::result_t               res_nxt;
  mtg_pkg::result_t               res_r;
  logic                           out_valid_r;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[mtg_pkg::ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r   <= mtg_pkg::LIMIT_RST;
      hyst_r    <= mtg_pkg::HYST_RST;
      timeout_r <= mtg_pkg::TIMEOUT_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        mtg_pkg::REG_LIMIT:   limit_r   <= pwdata[mtg_pkg::LIMIT_W-1:0];
        mtg_pkg::REG_HYST:    hyst_r    <= pwdata[mtg_pkg::LIMIT_W-1:0];
        mtg_pkg::REG_TIMEOUT: timeout_r <= pwdata[mtg_pkg::TIMEOUT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_idx)
      mtg_pkg::REG_LIMIT:   prdata = mtg_pkg::DATA_W'(limit_r);
      mtg_pkg::REG_HYST:    prdata = mtg_pkg::DATA_W'(hyst_r);
      mtg_pkg::REG_TIMEOUT: prdata = mtg_pkg::DATA_W'(timeout_r);
      default:              prdata = '0;
    endcase
  end

  // timeout at the wait counter width
  assign timeout_w = WAIT_BITS'(timeout_r);

  // handshake: the stage moves when the output register is free or draining
  assign advance  = stg_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !stg_valid_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ready) begin
      stg_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_cmd_r    <= in_cmd;
      stg_temp_r   <= in_temperature;
      stg_fail_r   <= in_sensor_fail;
      stg_sealed_r <= in_sealed;
    end
  end

  // guard logic
  mtg_core #(
    .TEMP_BITS (TEMP_BITS),
    .WAIT_BITS (WAIT_BITS)
  ) u_core (
    .flags_cur   (flags_r),
    .wait_cur    (wait_count_r),
    .cmd         (stg_cmd_r),
    .temperature (stg_temp_r),
    .sensor_fail (stg_fail_r),
    .sealed      (stg_sealed_r),
    .limit       (limit_r),
    .hyst        (hyst_r),
    .timeout     (timeout_w),
    .flags_nxt   (flags_nxt),
    .wait_nxt    (wait_count_nxt),
    .res         (res_nxt)
  );

  // guard state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r      <= mtg_pkg::FLAGS_RST;
      wait_count_r <= '0;
    end else if (advance) begin
      flags_r      <= flags_nxt;
      wait_count_r <= wait_count_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_motor_on  = res_r.motor_on;
  assign out_buzzer_on = res_r.buzzer_on;
  assign out_alarm_led = res_r.alarm_led;
  assign out_status    = res_r.status;
  assign out_stopping  = res_r.stopping;

  // a pending stop always has the relay still energized
  a_pending_relay: assert property (@(posedge clk) disable iff (!rst_n)
    flags_r.stop_pending |-> flags_r.relay_state)
    else $error("stop pending with relay released");

  // a latched fault never clears and never keeps a resume
  a_fault_latch: assert property (@(posedge clk) disable iff (!rst_n)
    flags_r.alarm_code[1] |=> flags_r.alarm_code[1])
    else $error("latched fault cleared");

  a_fault_no_resume: assert property (@(posedge clk) disable iff (!rst_n)
    flags_r.alarm_code[1] |-> !flags_r.resume_run)
    else $error("resume armed during fault");

  // state moves only together with a new result
  a_state_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(flags_r) |-> out_valid_r)
    else $error("state changed without a result");

endmodule

`default_nettype wire
